FILE: hw/rtl/eiec_pkg.sv
// eiec_pkg: types, codes and helper functions for the external interrupt edge controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package eiec_pkg;

	// line and port geometry
	localparam int NUM_LINES = 16;
	localparam int NUM_PORTS = 4;
	localparam int LEVEL_W   = 16;
	localparam int CODE_W    = 4;
	localparam int IRQ_W     = 7;
	localparam int PSEL_W    = NUM_LINES * CODE_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	// item commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RISING  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALLING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PORTSEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_EN  = 3'd4;

	// source port codes
	localparam logic [CODE_W-1:0] SRC_PORT_A = 4'd0;
	localparam logic [CODE_W-1:0] SRC_PORT_B = 4'd1;
	localparam logic [CODE_W-1:0] SRC_PORT_C = 4'd2;
	localparam logic [CODE_W-1:0] SRC_PORT_D = 4'd3;

	// configuration bundle handed to the edge unit
	typedef struct packed {
		logic [LEVEL_W-1:0] rising_select;
		logic [LEVEL_W-1:0] falling_select;
		logic [LEVEL_W-1:0] line_mask;
		logic [PSEL_W-1:0]  port_select;
		logic [IRQ_W-1:0]   irq_enable;
	} cfg_t;

	// per line source selection, unused codes hold the line low
	function automatic logic [LEVEL_W-1:0] line_levels(
		input logic [LEVEL_W-1:0] pa,
		input logic [LEVEL_W-1:0] pb,
		input logic [LEVEL_W-1:0] pc,
		input logic [LEVEL_W-1:0] pd,
		input logic [PSEL_W-1:0]  psel
	);
		logic [LEVEL_W-1:0] lv;
		logic [CODE_W-1:0]  code;
		lv = '0;
		for (int n = 0; n < NUM_LINES; n++) begin
			code = psel[n*CODE_W +: CODE_W];
			unique case (code)
				SRC_PORT_A: lv[n] = pa[n];
				SRC_PORT_B: lv[n] = pb[n];
				SRC_PORT_C: lv[n] = pc[n];
				SRC_PORT_D: lv[n] = pd[n];
				default:    lv[n] = 1'b0;
			endcase
		end
		return lv;
	endfunction

	// interrupt request grouping and gating
	function automatic logic [IRQ_W-1:0] irq_out(
		input logic [LEVEL_W-1:0] p,
		input logic [IRQ_W-1:0]   en
	);
		logic [IRQ_W-1:0] r;
		r[4:0] = p[4:0];
		r[5]   = |p[9:5];
		r[6]   = |p[15:10];
		return r & en;
	endfunction

endpackage

FILE: hw/rtl/eiec_cfg_regs.sv
// eiec_cfg_regs: configuration register file written through the cfg word channel
// depends on eiec_pkg
`timescale 1ns / 1ps

module eiec_cfg_regs import eiec_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register write decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RISING:  cfg_q.rising_select  <= cfg_data[LEVEL_W-1:0];
				REG_FALLING: cfg_q.falling_select <= cfg_data[LEVEL_W-1:0];
				REG_MASK:    cfg_q.line_mask      <= cfg_data[LEVEL_W-1:0];
				REG_PORTSEL: cfg_q.port_select    <= cfg_data[PSEL_W-1:0];
				REG_IRQ_EN:  cfg_q.irq_enable     <= cfg_data[IRQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/eiec_edge_unit.sv
// eiec_edge_unit: line level tracking, edge detection and pending bit state
// depends on eiec_pkg
`timescale 1ns / 1ps

module eiec_edge_unit import eiec_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic               cmd,
	input  logic [LEVEL_W-1:0] port_a,
	input  logic [LEVEL_W-1:0] port_b,
	input  logic [LEVEL_W-1:0] port_c,
	input  logic [LEVEL_W-1:0] port_d,
	input  logic [LEVEL_W-1:0] clear_bits,
	input  cfg_t               cfg,
	output logic [LEVEL_W-1:0] pending_next,
	output logic [IRQ_W-1:0]   irq_next
);

	logic [LEVEL_W-1:0] prev_q;
	logic [LEVEL_W-1:0] pending_q;
	logic [LEVEL_W-1:0] cur;
	logic [LEVEL_W-1:0] hit;
	logic [LEVEL_W-1:0] prev_next;

	// edge detection against the last sampled levels
	always_comb begin
		cur = line_levels(port_a, port_b, port_c, port_d, cfg.port_select);
		hit = ((cur & ~prev_q & cfg.rising_select) |
		       (prev_q & ~cur & cfg.falling_select)) & cfg.line_mask;
		if (cmd == CMD_SAMPLE) begin
			pending_next = pending_q | hit;
			prev_next    = cur;
		end else begin
			pending_next = pending_q & ~clear_bits;
			prev_next    = prev_q;
		end
		irq_next = irq_out(pending_next, cfg.irq_enable);
	end

	// state update once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			pending_q <= '0;
		end else if (upd) begin
			prev_q    <= prev_next;
			pending_q <= pending_next;
		end
	end

	// clear words leave the level history alone
	assert property (@(posedge clk) disable iff (!arst_n)
		upd && cmd == CMD_CLEAR |=> prev_q == $past(prev_q))
		else $error("level history changed on a clear word");

	// sampling never drops a pending bit
	assert property (@(posedge clk) disable iff (!arst_n)
		upd && cmd == CMD_SAMPLE |=> (pending_q & $past(pending_q)) == $past(pending_q))
		else $error("pending bit lost on a sample word");

	// clearing never raises a pending bit
	assert property (@(posedge clk) disable iff (!arst_n)
		upd && cmd == CMD_CLEAR |=> (pending_q & ~$past(pending_q)) == '0)
		else $error("pending bit set on a clear word");

	// masked lines never become pending
	assert property (@(posedge clk) disable iff (!arst_n)
		upd && cmd == CMD_SAMPLE |=>
		(pending_q & ~$past(pending_q) & ~$past(cfg.line_mask)) == '0)
		else $error("masked line became pending");

endmodule

FILE: hw/rtl/external_interrupt_edge_controller.sv
// external_interrupt_edge_controller: top level, input stage, edge unit and result stage
// depends on eiec_pkg, eiec_cfg_regs, eiec_edge_unit
// path: a taken word is held in the input stage, passes through the edge unit and is registered in the result stage
// throughput: one word per cycle while no result word is held, set by the single pass through the edge unit
// stalls: a held result word backs up into the input stage, in_ready drops once both are full
// reset: all configuration, level history and pending bits clear to zero
`timescale 1ns / 1ps

module external_interrupt_edge_controller import eiec_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [LEVEL_W-1:0]   port_a_levels,
	input  logic [LEVEL_W-1:0]   port_b_levels,
	input  logic [LEVEL_W-1:0]   port_c_levels,
	input  logic [LEVEL_W-1:0]   port_d_levels,
	input  logic [LEVEL_W-1:0]   clear_bits,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LEVEL_W-1:0]   pending_lines,
	output logic [IRQ_W-1:0]     irq_lines,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t               cfg;
	logic               valid_s1;
	logic               cmd_s1;
	logic [LEVEL_W-1:0] port_a_s1;
	logic [LEVEL_W-1:0] port_b_s1;
	logic [LEVEL_W-1:0] port_c_s1;
	logic [LEVEL_W-1:0] port_d_s1;
	logic [LEVEL_W-1:0] clear_s1;
	logic               valid_s2;
	logic [LEVEL_W-1:0] pending_s2;
	logic [IRQ_W-1:0]   irq_s2;
	logic [LEVEL_W-1:0] pending_next;
	logic [IRQ_W-1:0]   irq_next;
	logic               adv;

	// configuration registers
	eiec_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage handshake
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input word register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= cmd;
			port_a_s1 <= port_a_levels;
			port_b_s1 <= port_b_levels;
			port_c_s1 <= port_c_levels;
			port_d_s1 <= port_d_levels;
			clear_s1  <= clear_bits;
		end
	end

	// edge detection and pending state
	eiec_edge_unit u_edge (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (adv),
		.cmd          (cmd_s1),
		.port_a       (port_a_s1),
		.port_b       (port_b_s1),
		.port_c       (port_c_s1),
		.port_d       (port_d_s1),
		.clear_bits   (clear_s1),
		.cfg          (cfg),
		.pending_next (pending_next),
		.irq_next     (irq_next)
	);

	// result word register
	always_ff @(posedge clk) begin
		if (adv) begin
			pending_s2 <= pending_next;
			irq_s2     <= irq_next;
		end
	end

	assign out_valid     = valid_s2;
	assign pending_lines = pending_s2;
	assign irq_lines     = irq_s2;

endmodule
